/* src/b64sd_pkg.sv */
// b64sd_pkg: shared types, code constants and the character mapping function
// for the base64 stream decoder. No dependencies.
package b64sd_pkg;

  // 7-bit character codes: 0..63 are sextets, then pad and invalid
  localparam logic [6:0] CodePad     = 7'h40;
  localparam logic [6:0] CodeInvalid = 7'h41;

  // one decoded quartet handed from the quartet stage to the output stage
  typedef struct packed {
    logic       load;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } grp_t;

  // a code is a sextet when its top bit is clear
  function automatic logic is_sextet(input logic [6:0] code);
    return ~code[6];
  endfunction

  // ASCII character to 7-bit code
  function automatic logic [6:0] map_char(input logic [7:0] c);
    logic [7:0] diff;
    logic [6:0] code;
    diff = 8'd0;
    code = CodeInvalid;
    if (c >= 8'h41 && c <= 8'h5A) begin
      // 'A'..'Z' -> 0..25
      diff = c - 8'd65;
      code = diff[6:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      // 'a'..'z' -> 26..51
      diff = c - 8'd71;
      code = diff[6:0];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      // '0'..'9' -> 52..61
      diff = c + 8'd4;
      code = diff[6:0];
    end else if (c == 8'h2B) begin
      code = 7'd62;
    end else if (c == 8'h2F) begin
      code = 7'd63;
    end else if (c == 8'h3D) begin
      code = CodePad;
    end
    return code;
  endfunction

endpackage

/* src/b64sd_quartet.sv */
// b64sd_quartet: maps characters to codes, holds the first three codes of a
// quartet and decodes the full quartet on the fourth. Depends on b64sd_pkg.
module b64sd_quartet import b64sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_text_i,
  input  logic       grp_free_i,
  output grp_t       grp_o
);

  logic [6:0] held_q [3];
  logic [1:0] pos_q, pos_d;
  logic       accept;
  logic [6:0] code;
  logic [6:0] v0, v1, v2;
  logic [1:0] low2;
  logic       keep;

  // the fourth character needs the output group register free
  assign in_ready_o = (pos_q != 2'd3) || grp_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign code       = map_char(char_in_i);

  assign v0 = held_q[0];
  assign v1 = held_q[1];
  assign v2 = held_q[2];

  // quartet decode
  assign keep = is_sextet(v0) && is_sextet(v1) &&
                (v2 != CodeInvalid) && (code != CodeInvalid);
  assign low2 = is_sextet(v2) ? v2[1:0] : 2'b11;

  always_comb begin
    grp_o.load = accept && (pos_q == 2'd3) && keep;
    grp_o.b1   = {v0[5:0], v1[5:4]};
    grp_o.b2   = is_sextet(v2) ? {v1[3:0], v2[5:2]} : 8'd0;
    grp_o.b3   = is_sextet(code) ? {low2, code[5:0]} : 8'd0;
  end

  // position in quartet
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = pos_q + 2'd1;
      if (end_of_text_i) begin
        pos_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // held codes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q[0] <= 7'd0;
      held_q[1] <= 7'd0;
      held_q[2] <= 7'd0;
    end else if (accept) begin
      unique case (pos_q)
        2'd0:    held_q[0] <= code;
        2'd1:    held_q[1] <= code;
        2'd2:    held_q[2] <= code;
        default: ;
      endcase
    end
  end

endmodule

/* src/b64sd_out.sv */
// b64sd_out: result register for one decoded quartet, drained one byte per
// output transaction. Depends on b64sd_pkg.
module b64sd_out import b64sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  grp_t       grp_i,
  output logic       grp_free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       last_of_group_o
);

  logic [7:0] b1_q, b2_q, b3_q;
  logic [1:0] cnt_q, cnt_d;

  assign grp_free_o  = (cnt_q == 2'd0);
  assign out_valid_o = (cnt_q != 2'd0);

  // byte select from remaining count
  always_comb begin
    case (cnt_q)
      2'd3:    byte_out_o = b1_q;
      2'd2:    byte_out_o = b2_q;
      default: byte_out_o = b3_q;
    endcase
  end
  assign last_of_group_o = (cnt_q == 2'd1);

  // remaining byte count
  always_comb begin
    cnt_d = cnt_q;
    if (grp_i.load) begin
      cnt_d = 2'd3;
    end else if (out_valid_o && out_ready_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // group payload
  always_ff @(posedge clk_i) begin
    if (grp_i.load) begin
      b1_q <= grp_i.b1;
      b2_q <= grp_i.b2;
      b3_q <= grp_i.b3;
    end
  end

  // a group is only loaded into an empty register
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_i.load |-> (cnt_q == 2'd0))
    else $error("group loaded while bytes pending");

  // a stalled receiver keeps the pending count
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(cnt_q))
    else $error("pending count changed under stall");

  // after the third byte the register is empty or freshly loaded
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_of_group_o) |=> (cnt_q == 2'd0 || cnt_q == 2'd3))
    else $error("group not drained after last byte");

endmodule

/* src/base64_stream_decoder_unit.sv */
// base64_stream_decoder_unit: top level of the base64 stream decoder.
// Depends on b64sd_pkg, b64sd_quartet and b64sd_out.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one ASCII character per
//   transaction, with end_of_text_i marking the last character; a partial
//   quartet left after it is dropped.
//   Output channel (out_valid_o/out_ready_i) carries decoded bytes, three per
//   accepted quartet, last_of_group_o high on the third. Quartets with a bad
//   or padded first/second character or an invalid third/fourth give nothing.
//   Latency: the first byte of a quartet is offered in the cycle after its
//   fourth character is taken; the other two follow one per cycle while out_ready_i is high.
//   Throughput: one character per cycle; the three bytes of a quartet drain
//   from the single group register, if the output does not stall, while the
//   next quartet's first three characters are taken. The group register sets
//   the limit: a quartet's fourth character waits while earlier bytes remain.
//   Reset: asynchronous, active low; clears the quartet position, held codes
//   and pending byte count, so the output is empty afterwards.
//   Stall: while out_ready_i is low the current byte holds; characters one to
//   three of the next quartet are still taken, the fourth waits.
module base64_stream_decoder_unit import b64sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       last_of_group_o
);

  grp_t grp;
  logic grp_free;

  // character mapping and quartet decode
  b64sd_quartet u_quartet (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .grp_free_i    (grp_free),
    .grp_o         (grp)
  );

  // byte drain
  b64sd_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .grp_i           (grp),
    .grp_free_o      (grp_free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .byte_out_o      (byte_out_o),
    .last_of_group_o (last_of_group_o)
  );

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for base64_stream_decoder_unit, random and directed
// character streams against a behavioural quartet decoder kept in the bench.
// Depends on b64sd_pkg and the unit's RTL.
module tb_top;
  import b64sd_pkg::*;

  localparam int CharTarget = 410;
  localparam int CalmTail   = 50;
  localparam int CycleLimit = 300000;
  localparam int TailCycles = 20;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    logic       hold;   // wait for the output side to drain before sending
  } char_item_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } byte_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_in_i = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] byte_out_o;
  logic       last_of_group_o;

  char_item_t chars_pending[$];
  byte_item_t bytes_due[$];

  // predictor state
  logic [6:0] held_code[3];
  logic [1:0] group_pos;

  logic char_taken = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   failures = 0;
  int   cycles = 0;

  base64_stream_decoder_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_in_i      (char_in_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_out_o     (byte_out_o),
    .last_of_group_o(last_of_group_o)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ascii character to code: sextet, pad or invalid
  function automatic logic [6:0] code_of_char(input logic [7:0] ch);
    logic [6:0] code;
    code = CodeInvalid;
    if (ch inside {[8'h41:8'h5A]}) code = 7'(ch - 8'h41);
    else if (ch inside {[8'h61:8'h7A]}) code = 7'(ch - 8'h61 + 8'd26);
    else if (ch inside {[8'h30:8'h39]}) code = 7'(ch - 8'h30 + 8'd52);
    else if (ch == 8'h2B) code = 7'd62;
    else if (ch == 8'h2F) code = 7'd63;
    else if (ch == 8'h3D) code = CodePad;
    return code;
  endfunction

  // sextet value to its base64 character
  function automatic logic [7:0] char_of_sextet(input int unsigned v);
    if (v < 26) return 8'(8'h41 + v);
    if (v < 52) return 8'(8'h61 + v - 26);
    if (v < 62) return 8'(8'h30 + v - 52);
    if (v == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  // idle chance in percent, varying along the run so some stretches stay busy
  function automatic int idle_chance();
    int phase;
    phase = (chars_pending.size() / 48) % 3;
    if (chars_pending.size() < CalmTail || phase == 0) return 0;
    return (phase == 1) ? 12 : 35;
  endfunction

  // one accepted character: update the quartet and queue any decoded bytes
  task automatic decode_char(input logic [7:0] ch, input logic eot);
    logic [6:0] code;
    logic [7:0] b1, b2, b3;
    logic [1:0] low2;
    code = code_of_char(ch);
    if (group_pos < 2'd3) begin
      held_code[group_pos] = code;
      group_pos = group_pos + 2'd1;
    end else begin
      group_pos = 2'd0;
      if (held_code[0] < 7'd64 && held_code[1] < 7'd64 &&
          held_code[2] != CodeInvalid && code != CodeInvalid) begin
        b1 = {held_code[0][5:0], held_code[1][5:4]};
        b2 = (held_code[2] < 7'd64) ? {held_code[1][3:0], held_code[2][5:2]} : 8'h00;
        // a pad in the third position counts as ones in its low bits
        low2 = (held_code[2] < 7'd64) ? held_code[2][1:0] : 2'b11;
        b3 = (code < 7'd64) ? {low2, code[5:0]} : 8'h00;
        bytes_due.push_back('{value: b1, last: 1'b0});
        bytes_due.push_back('{value: b2, last: 1'b0});
        bytes_due.push_back('{value: b3, last: 1'b1});
      end
    end
    if (eot) group_pos = 2'd0;
  endtask

  task automatic add_char(input logic [7:0] ch, input logic eot, input logic hold);
    chars_pending.push_back('{ch: ch, eot: eot, hold: hold});
  endtask

  task automatic add_text(input string s, input logic eot_at_end);
    for (int i = 0; i < s.len(); i++)
      add_char(s[i], eot_at_end && (i == s.len() - 1), 1'b0);
  endtask

  // output check and input transaction capture
  always @(posedge clk_i) begin : check_bytes
    byte_item_t want;
    cycles++;
    if (rst_ni) begin
      char_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (bytes_due.size() == 0) begin
          $display("%0t: byte with none expected, actual byte %h last %b",
                   $time, byte_out_o, last_of_group_o);
          failures++;
        end else begin
          want = bytes_due.pop_front();
          if (byte_out_o !== want.value) begin
            $display("%0t: byte_out expected %h actual %h", $time, want.value, byte_out_o);
            failures++;
          end
          if (last_of_group_o !== want.last) begin
            $display("%0t: last_of_group expected %b actual %b",
                     $time, want.last, last_of_group_o);
            failures++;
          end
        end
      end
      if (in_valid_i && in_ready_o) decode_char(char_in_i, end_of_text_i);
    end
  end

  // character driver
  always @(negedge clk_i) begin : drive_chars
    char_item_t nxt;
    if (rst_ni && (!in_valid_i || char_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (chars_pending.size() == 0 ||
                   (chars_pending[0].hold && bytes_due.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_chance()) begin
        send_gap <= $urandom_range(0, 12);
        in_valid_i <= 1'b0;
      end else begin
        nxt = chars_pending.pop_front();
        char_in_i <= nxt.ch;
        end_of_text_i <= nxt.eot;
        in_valid_i <= 1'b1;
      end
    end
  end

  // output side stalls
  always @(negedge clk_i) begin : drive_ready
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_chance()) begin
      stall_left <= $urandom_range(0, 12);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("base64_stream_decoder_unit verification failed");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int sel, r, cut, bad_pos;
    logic [7:0] q[4];
    logic hold_next;
    held_code[0] = 7'd0;
    held_code[1] = 7'd0;
    held_code[2] = 7'd0;
    group_pos = 2'd0;

    // directed: plain quartet, pad then data, pad in fourth with end of text
    add_text("TWFu", 1'b0);
    add_text("AB=/", 1'b0);
    add_text("//8=", 1'b1);
    // rejected: pad first and zero char fourth, then invalid third
    add_text("=AA", 1'b0);
    add_char(8'h00, 1'b0, 1'b0);
    add_text("AA", 1'b0);
    add_char(8'hFF, 1'b0, 1'b0);
    add_text("A", 1'b0);
    // partial quartet cut by end of text
    add_text("QU", 1'b1);

    // random part, mostly well-formed quartets
    hold_next = 1'b1;
    while (chars_pending.size() < CharTarget) begin
      if (chars_pending.size() > 200 && chars_pending.size() < 205) hold_next = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        for (int i = 0; i < 4; i++) q[i] = char_of_sextet($urandom_range(0, 63));
        r = $urandom_range(0, 9);
        if (r == 0) begin
          q[2] = 8'h3D;
          q[3] = 8'h3D;
        end else if (r == 1) begin
          q[2] = 8'h3D;
        end else if (r == 2) begin
          q[3] = 8'h3D;
        end
        // corrupt one position with any byte
        if (sel >= 70) begin
          bad_pos = $urandom_range(0, 3);
          q[bad_pos] = 8'($urandom_range(0, 255));
        end
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 4;
        for (int i = 0; i < cut; i++)
          add_char(q[i], (i == cut - 1) && (cut < 4 || $urandom_range(0, 9) == 0),
                   hold_next && i == 0);
        hold_next = 1'b0;
      end else begin
        add_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0, hold_next);
        hold_next = 1'b0;
      end
    end

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    @(posedge clk_i);
    while (chars_pending.size() != 0 || in_valid_i || bytes_due.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (failures == 0) begin
      $display("base64_stream_decoder_unit verification clean");
    end else begin
      $display("base64_stream_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
